@@ rtl/core/mono_last_note_priority_core_assert.svh @@
// Assertion helpers used by the core top file.
`ifndef MONO_LAST_NOTE_PRIORITY_CORE_ASSERT_SVH
`define MONO_LAST_NOTE_PRIORITY_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MLNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mlnp_pkg.sv @@
package mlnp_pkg;

   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_ALL_OFF  = 2'd2;

   localparam logic [4:0] CHAN_OMNI  = 5'd0;
   localparam logic [4:0] CHAN_LAST  = 5'd16;
   localparam logic [6:0] NOTE_RESET = 7'd69;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] event_channel;
      logic [6:0] note_number;
      logic [6:0] note_velocity;
   } req_type;

   typedef struct packed {
      logic       gate;
      logic [6:0] pitch_note;
      logic [6:0] held_velocity;
      logic       env_trigger;
      logic       env_release;
      logic       pitch_update;
      logic       ignored;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_UPDATE
   } state_type;

   // Operation the controller asks of the note stack this cycle.
   typedef struct packed {
      logic remove;
      logic push;
      logic clear;
   } stack_cmd_type;

   // Per-cell shift control, common to every cell of the row.
   typedef struct packed {
      logic remove;
      logic shift_all;
   } cell_ctl_type;

endpackage

@@ rtl/core/mlnp_cell.sv @@
module mlnp_cell
   import mlnp_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         load,
   input  logic         valid,
   input  logic [6:0]   key,
   input  logic [6:0]   right_note,
   input  logic         found_in,
   output logic [6:0]   note,
   output logic         found_out
);

   logic [6:0] note_ff;
   logic [6:0] note_in;
   logic       match;
   logic       shift;

   assign match     = valid && (note_ff == key);
   assign found_out = found_in || match;
   // Once the removed note is found at or below this cell, pull from the right.
   assign shift     = (ctl.remove && found_out) || ctl.shift_all;

   always_comb begin
      if (load) begin
         note_in = key;
      end else if (shift) begin
         note_in = right_note;
      end else begin
         note_in = note_ff;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

   assign note = note_ff;

endmodule

@@ rtl/core/mlnp_stack.sv @@
module mlnp_stack
   import mlnp_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  stack_cmd_type                cmd,
   input  logic [6:0]                   key,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic [6:0]                   top_note
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [6:0]       notes [DEPTH];
   logic [DEPTH:0]   found;
   logic [DEPTH-1:0] load;
   logic             full;
   cell_ctl_type     ctl;
   logic [IW-1:0]    top_idx;

   assign full          = (count_ff == CW'(DEPTH));
   assign ctl.remove    = cmd.remove;
   assign ctl.shift_all = cmd.push && full;
   assign found[0]      = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [6:0] right;
      if (i == DEPTH - 1) begin : g_end
         assign right = key;
      end else begin : g_mid
         assign right = notes[i+1];
      end
      // Write at the first free slot, or at the top after the oldest drops out.
      assign load[i] = cmd.push && (full ? (i == DEPTH - 1) : (CW'(i) == count_ff));

      mlnp_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load       (load[i]),
         .valid      (CW'(i) < count_ff),
         .key        (key),
         .right_note (right),
         .found_in   (found[i]),
         .note       (notes[i]),
         .found_out  (found[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.remove && found[DEPTH]) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.push && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_idx  = IW'(count_ff - 1'b1);
   assign top_note = notes[top_idx];
   assign count    = count_ff;

endmodule

@@ rtl/core/mono_last_note_priority_core.sv @@
// A note event's result is registered out of ST_UPDATE, after ST_REMOVE; an ignored,
// all-notes-off or unused event's result is registered out of ST_REMOVE.
// A new event is taken only back in ST_IDLE (busy low), after the remove pass over the
// row of stack cells and, for note events, the update pass that pushes note-ons.
// Reset (synchronous): empty stack, gate low, pitch 69, velocity 0, omni channel.
// Results cannot be stalled; each is shown for exactly one cycle.
module mono_last_note_priority_core
   import mlnp_pkg::*;
#(
   parameter int STACK_DEPTH = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

`include "mono_last_note_priority_core_assert.svh"

   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type     state_ff;
   state_type     state_in;
   req_type       item_ff;
   logic [4:0]    listen_ff;
   logic          sounding_ff;
   logic          sounding_in;
   logic [6:0]    target_ff;
   logic [6:0]    target_in;
   logic [6:0]    velocity_ff;
   logic [6:0]    velocity_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   stack_cmd_type stack_cmd;
   logic [CW-1:0] count;
   logic [6:0]    top_note;
   logic [4:0]    listen_eff;
   logic          chan_ok;
   logic          is_note;
   logic          is_on;
   logic          accept;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = !busy;
   assign listen_eff = (listen_ff > CHAN_LAST) ? CHAN_OMNI : listen_ff;
   assign chan_ok    = (listen_eff == CHAN_OMNI) || (listen_eff == item_ff.event_channel);
   assign is_note    = (item_ff.cmd == CMD_NOTE_ON) || (item_ff.cmd == CMD_NOTE_OFF);
   assign is_on      = (item_ff.cmd == CMD_NOTE_ON) && (item_ff.note_velocity != 7'd0);

   mlnp_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (stack_cmd),
      .key      (item_ff.note_number),
      .count    (count),
      .top_note (top_note)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            state_in = (is_note && chan_ok) ? ST_UPDATE : ST_IDLE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      stack_cmd    = '0;
      sounding_in  = sounding_ff;
      target_in    = target_ff;
      velocity_in  = velocity_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_REMOVE: begin
            if (is_note) begin
               if (chan_ok) begin
                  stack_cmd.remove = 1'b1;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.ignored = 1'b1;
               end
            end else if (item_ff.cmd == CMD_ALL_OFF) begin
               rsp_valid_in = 1'b1;
               if ((item_ff.event_channel != CHAN_OMNI) && !chan_ok) begin
                  rsp_in.ignored = 1'b1;
               end else begin
                  // Panic or matching all-notes-off: drop everything.
                  stack_cmd.clear    = 1'b1;
                  sounding_in        = 1'b0;
                  rsp_in.env_release = sounding_ff;
               end
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            if (is_on) begin
               stack_cmd.push      = 1'b1;
               target_in           = item_ff.note_number;
               velocity_in         = item_ff.note_velocity;
               sounding_in         = 1'b1;
               rsp_in.env_trigger  = 1'b1;
               rsp_in.pitch_update = 1'b1;
            end else if (count != '0) begin
               // Fall back legato to the new top.
               target_in           = top_note;
               rsp_in.pitch_update = 1'b1;
            end else begin
               sounding_in        = 1'b0;
               rsp_in.env_release = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_in.gate          = sounding_in;
      rsp_in.pitch_note    = target_in;
      rsp_in.held_velocity = velocity_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         listen_ff    <= CHAN_OMNI;
         sounding_ff  <= 1'b0;
         target_ff    <= NOTE_RESET;
         velocity_ff  <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sounding_ff  <= sounding_in;
         target_ff    <= target_in;
         velocity_ff  <= velocity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            listen_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MLNP_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted word did not raise busy")
   `MLNP_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result strobed while busy")
   `MLNP_ASSERT_NOW(a_trig_gate, clock, reset, rsp_valid && rsp_data.env_trigger,
      rsp_data.gate && rsp_data.pitch_update && !rsp_data.env_release,
      "trigger without gate and pitch update")
   `MLNP_ASSERT_NOW(a_ignored_quiet, clock, reset, rsp_valid && rsp_data.ignored,
      !rsp_data.env_trigger && !rsp_data.env_release && !rsp_data.pitch_update,
      "ignored word carries flags")

endmodule
